// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
// Shared request kinds, status codes and field widths of the bounded deque.
package bdq_pkg;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ----- rtl/bounded_deque_with_search_top.sv -----
// Bounded double-ended queue of signed words with a linear search, top level.
//
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_ready) with a
//   kind (push front, push back, pop front, pop back, find) and a word.
//   Each request gives exactly one result on the output channel
//   (o_out_valid / i_out_ready): status, popped word, found position and
//   the entry count after the request.
//   The block takes one request at a time. Pushes and failed pops pass
//   through S_EXEC and S_DONE, pops through S_EXEC, S_POPW and S_DONE.
//   A find reads the single port of the ring store once per cycle,
//   starting at the front; that read port and the compare behind it
//   set the rate. The result sits in an output register, so a new request
//   is taken while the previous result waits; a stalled receiver holds the
//   result and the block waits before writing the next one over it.
//   Reset empties the queue at once (front pointer and count to zero);
//   the ring store itself is not cleared, as only held entries are read.
module bounded_deque_with_search_top #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bdq_pkg::KIND_W-1:0]     i_kind,
    input  logic signed [bdq_pkg::VALUE_W-1:0] i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bdq_pkg::STATUS_W-1:0]   o_status,
    output logic signed [bdq_pkg::VALUE_W-1:0] o_popped_value,
    output logic [bdq_pkg::POS_W-1:0]      o_found_position,
    output logic [bdq_pkg::COUNT_W-1:0]    o_entry_count
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = DATA_WIDTH;

    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POPW = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Ring store and its registered read port
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    // Control state
    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // Request, iteration and result registers
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [DW-1:0]       r_word, n_word;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [DW-1:0]       r_res_pop, n_res_pop;
    logic [AW-1:0]       r_res_pos, n_res_pos;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [VALUE_W-1:0]  r_out_popped, n_out_popped;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic [63:0]   in_wide;
    logic [63:0]   pop_wide;
    logic [63:0]   pos_wide;
    logic [63:0]   cnt_wide;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] front_dec;

    // Ring index: base plus offset, wrapped at DEPTH
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    // Width conversions of the payload
    assign in_wide   = 64'(i_value);
    assign pop_wide  = 64'($signed(r_res_pop));
    assign pos_wide  = 64'(r_res_pos);
    assign cnt_wide  = 64'(r_count);
    assign cnt_m1    = r_count - CW'(1);
    assign front_dec = (r_front == '0) ? LAST_SLOT : (r_front - AW'(1));

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence one request through the shared store port
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_kind       = r_kind;
        n_word       = r_word;
        n_rd_idx     = r_rd_idx;
        n_cmp_idx    = r_cmp_idx;
        n_res_status = r_res_status;
        n_res_pop    = r_res_pop;
        n_res_pos    = r_res_pos;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        wr_en        = 1'b0;
        wr_addr      = r_front;
        rd_en        = 1'b0;
        rd_addr      = r_front;

        // Drop the held result once transferred
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_word  = in_wide[DW-1:0];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_pop    = '0;
                n_res_pos    = '0;
                n_state      = S_DONE;
                case (r_kind)
                    KIND_PUSH_FRONT: begin
                        if (r_count == DEPTH_C) begin
                            n_res_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = front_dec;
                            n_front = front_dec;
                            n_count = r_count + CW'(1);
                        end
                    end
                    KIND_PUSH_BACK: begin
                        if (r_count == DEPTH_C) begin
                            n_res_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = slot(r_front, r_count[AW-1:0]);
                            n_count = r_count + CW'(1);
                        end
                    end
                    KIND_POP_FRONT: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_front;
                            n_state = S_POPW;
                        end
                    end
                    KIND_POP_BACK: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = slot(r_front, cnt_m1[AW-1:0]);
                            n_state = S_POPW;
                        end
                    end
                    KIND_FIND: begin
                        if (r_count == '0) begin
                            n_res_status = ST_NOT_FOUND;
                        end else begin
                            rd_en     = 1'b1;
                            rd_addr   = r_front;
                            n_rd_idx  = CW'(1);
                            n_cmp_idx = '0;
                            n_state   = S_FIND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POPW: begin
                n_res_pop = r_rd_data;
                n_count   = cnt_m1;
                if (r_kind == KIND_POP_FRONT) begin
                    n_front = slot(r_front, AW'(1));
                end
                n_state = S_DONE;
            end
            S_FIND: begin
                // Advance the read one entry ahead of the compare
                if (r_rd_idx < r_count) begin
                    rd_en     = 1'b1;
                    rd_addr   = slot(r_front, r_rd_idx[AW-1:0]);
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_idx = r_rd_idx[AW-1:0];
                end
                if (r_rd_data == r_word) begin
                    n_res_status = ST_OK;
                    n_res_pos    = r_cmp_idx;
                    n_state      = S_DONE;
                end else if (CW'(r_cmp_idx) == cnt_m1) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_pos    = '0;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_popped = pop_wide[VALUE_W-1:0];
                    n_out_pos    = pos_wide[POS_W-1:0];
                    n_out_count  = cnt_wide[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_word       <= n_word;
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_res_status <= n_res_status;
        r_res_pop    <= n_res_pop;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

    // Ring store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_word;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_popped_value   = r_out_popped;
    assign o_found_position = r_out_pos;
    assign o_entry_count    = r_out_count;

endmodule

// ----- rtl/bdq_checker.sv -----
// Port-level assertions for the bounded deque, bound to its top level.
`include "assert_macros.svh"

module bdq_checker #(
    parameter int DEPTH = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [bdq_pkg::STATUS_W-1:0]   o_status,
    input logic [bdq_pkg::VALUE_W-1:0]    o_popped_value,
    input logic [bdq_pkg::COUNT_W-1:0]    o_entry_count
);
    import bdq_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    // A result on offer stays until transferred
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")

    // Reset leaves no result on offer
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result after reset")

    // A refused push reports a full queue
    `ASSERT_CLK(a_full_count, o_out_valid && o_status == ST_FULL |-> o_entry_count == FULL_COUNT, "full status with room left")

    // A refused pop reports an empty queue
    `ASSERT_CLK(a_empty_count, o_out_valid && o_status == ST_EMPTY |-> o_entry_count == '0, "empty status with entries held")

    // Only a successful request may carry a popped word
    `ASSERT_CLK(a_pop_zero, o_out_valid && o_status != ST_OK |-> o_popped_value == '0, "popped word on failure")

endmodule

bind bounded_deque_with_search_top bdq_checker #(
    .DEPTH(DEPTH)
) u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_popped_value(o_popped_value),
    .o_entry_count (o_entry_count)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the bounded deque with linear search.
`timescale 1ns / 1ps

module tb_top;
    import bdq_pkg::*;

    localparam int DEPTH          = 64;
    localparam int DATA_WIDTH     = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;
    localparam int HISTORY_DEPTH  = 32;

    // Kind codes the block leaves unused; it must ignore them
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } t_deque_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] popped;
        logic [POS_W-1:0]          pos;
        logic [COUNT_W-1:0]        count;
    } t_deque_result;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_ready;
    logic [KIND_W-1:0]           i_kind       = KIND_PUSH_FRONT;
    logic signed [VALUE_W-1:0]   i_value      = '0;
    logic                        o_out_valid;
    logic                        i_out_ready  = 1'b0;
    logic [STATUS_W-1:0]         o_status;
    logic signed [VALUE_W-1:0]   o_popped_value;
    logic [POS_W-1:0]            o_found_position;
    logic [COUNT_W-1:0]          o_entry_count;

    // Shadow deque state
    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    logic [POS_W-1:0]      shadow_front = '0;
    logic [COUNT_W-1:0]    shadow_count = '0;

    t_deque_req            queued_requests [$];
    t_deque_result         expected_results [$];
    logic signed [VALUE_W-1:0] pushed_history [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    logic hold_go     = 1'b0;

    bounded_deque_with_search_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_popped_value   (o_popped_value),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    always #6 i_clk = ~i_clk;

    // Apply one request to the shadow deque and return the result it gives
    function automatic t_deque_result predict_deque(input t_deque_req rq);
        t_deque_result res;
        logic [POS_W-1:0] idx;
        res = '{status: ST_OK, popped: '0, pos: '0, count: '0};
        case (rq.kind)
            KIND_PUSH_FRONT: begin
                if (shadow_count == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_front = shadow_front - 1'b1;
                    shadow_words[shadow_front] = rq.value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            KIND_PUSH_BACK: begin
                if (shadow_count == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    idx = shadow_front + shadow_count[POS_W-1:0];
                    shadow_words[idx] = rq.value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped = shadow_words[shadow_front];
                    shadow_front = shadow_front + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    idx = shadow_front + shadow_count[POS_W-1:0] - 1'b1;
                    res.popped = shadow_words[idx];
                    shadow_count = shadow_count - 1'b1;
                end
            end
            KIND_FIND: begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < shadow_count; i++) begin
                    idx = shadow_front + POS_W'(i);
                    if (res.status == ST_NOT_FOUND && shadow_words[idx] == rq.value) begin
                        res.status = ST_OK;
                        res.pos    = POS_W'(i);
                    end
                end
            end
            default: ;
        endcase
        res.count = shadow_count;
        return res;
    endfunction

    // Word mix: small values for repeats, the extremes, and full-range noise
    function automatic logic signed [VALUE_W-1:0] rand_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return VALUE_W'($urandom_range(0, 15));
        else if (sel < 55) begin
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic add_request(input logic [KIND_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] value);
        queued_requests.push_back('{kind: kind, value: value});
        if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
            pushed_history.push_back(value);
            if (pushed_history.size() > HISTORY_DEPTH)
                void'(pushed_history.pop_front());
        end
    endtask

    // Bursts of pushes, pops and finds, with some stray kinds as noise
    task automatic add_random(input int n);
        int made, run, sel, k;
        logic [KIND_W-1:0] kind;
        logic signed [VALUE_W-1:0] word;
        made = 0;
        while (made < n) begin
            sel = $urandom_range(0, 99);
            run = $urandom_range(1, 16);
            for (k = 0; k < run && made < n; k++) begin
                word = rand_word();
                if (sel < 35) begin
                    kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
                end else if (sel < 60) begin
                    kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
                end else if (sel < 85) begin
                    kind = KIND_FIND;
                    if (pushed_history.size() != 0 && $urandom_range(0, 3) != 0)
                        word = pushed_history[$urandom_range(0, pushed_history.size() - 1)];
                end else if (sel < 95) begin
                    kind = KIND_W'($urandom_range(0, 7));
                end else begin
                    kind = KIND_W'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
                end
                add_request(kind, word);
                if (kind <= KIND_FIND)
                    made++;
            end
        end
    endtask

    // Wait until every request is sent and every result is back
    task automatic wait_drained();
        while (queued_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input int n);
        @(negedge i_clk);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        add_random(n);
        wait_drained();
    endtask

    // Driver: predict on each input transfer, then offer the next request
    always @(posedge i_clk) begin
        t_deque_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_kind     <= KIND_PUSH_FRONT;
            i_value    <= '0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_results.push_back(predict_deque('{kind: i_kind, value: i_value}));
            if (!i_in_valid || o_in_ready) begin
                if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = queued_requests.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind     <= nxt.kind;
                    i_value    <= nxt.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started by a pulse on hold_go
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d popped %0d pos %0d count %0d",
                                 o_status, o_popped_value, o_found_position, o_entry_count);
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status || o_popped_value !== want.popped ||
                        o_found_position !== want.pos || o_entry_count !== want.count) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $write("mismatch: expected status %0d popped %0d pos %0d count %0d, ",
                                   want.status, want.popped, want.pos, want.count);
                            $display("got status %0d popped %0d pos %0d count %0d",
                                     o_status, o_popped_value, o_found_position,
                                     o_entry_count);
                        end
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic signed [VALUE_W-1:0] first_word, last_word, word;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty deque: pops, find and an unused kind
        add_request(KIND_POP_FRONT, 32'h0000_0005);
        add_request(KIND_POP_BACK, 32'hFFFF_FFFF);
        add_request(KIND_FIND, 32'h0000_0000);
        add_request(KIND_SPARE_A, 32'h7FFF_FFFF);
        // Pushes at both ends with extreme words; front pointer wraps below zero
        add_request(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        add_request(KIND_PUSH_BACK, 32'h8000_0000);
        add_request(KIND_PUSH_FRONT, 32'h0000_0000);
        add_request(KIND_PUSH_BACK, 32'hFFFF_FFFF);
        add_request(KIND_PUSH_FRONT, 32'h0000_0001);
        // Finds: hits at both ends and the middle, and a miss
        add_request(KIND_FIND, 32'h8000_0000);
        add_request(KIND_FIND, 32'h0000_0001);
        add_request(KIND_FIND, 32'h1234_5678);
        add_request(KIND_FIND, 32'hFFFF_FFFF);
        add_request(KIND_SPARE_B, 32'h0000_0000);
        add_request(KIND_SPARE_C, 32'hA5A5_5A5A);
        // Drain from both ends, then one pop too many
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_BACK, 32'h0000_0000);
        add_request(KIND_POP_BACK, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_BACK, 32'h0000_0000);

        // Fill to the brim with distinct words, search both ends, overfill, drain
        first_word = '0;
        last_word  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            word = ($urandom & 32'hFFFF_FFC0) | VALUE_W'(i);
            if (i == 0)
                first_word = word;
            last_word = word;
            add_request(KIND_PUSH_BACK, word);
        end
        add_request(KIND_FIND, last_word);
        add_request(KIND_FIND, first_word);
        add_request(KIND_PUSH_FRONT, 32'h0000_0000);
        add_request(KIND_PUSH_BACK, 32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH; i++)
            add_request((i % 2 == 0) ? KIND_POP_FRONT : KIND_POP_BACK, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        wait_drained();

        run_phase(0, 0, 120);
        run_phase(46, 0, 120);
        run_phase(0, 46, 120);
        run_phase(31, 31, 120);

        // Receiver holds off while the sender keeps offering requests
        @(negedge i_clk);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go       = 1'b1;
        add_random(40);
        @(negedge i_clk);
        hold_go       = 1'b0;
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bounded_deque_with_search_top.sv
rtl/bdq_checker.sv
verif/tb_top.sv
